@@ design/page_frame_region_allocator_macros.svh @@
// Assertion macros for the page frame region allocator.
`ifndef PAGE_FRAME_REGION_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REGION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pfra_pkg.sv @@
package pfra_pkg;

    localparam int ADDR_BITS  = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int FRAME_BITS = ADDR_BITS - PAGE_SHIFT;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_EXCLUDE = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_IGNORED = 3'd1,
        ST_MIDDLE  = 3'd2,
        ST_OOM     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        frame_t start_frame;
        frame_t frame_count;
        frame_t next_free;
        frame_t free_left;
    } area_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIMPLE,
        S_EX_RD,
        S_EX_MOD,
        S_EX_DONE,
        S_AL_CHK
    } state_t;

endpackage

@@ design/page_frame_region_allocator.sv @@
// Channel   Dir  Signals                     Payload
// s_        in   s_tvalid s_tready           s_tdata: region_address, region_length
//                s_tdata s_tuser             s_tuser: op, usable
// m_        out  m_tvalid m_tready           m_tdata: frame_address
//                m_tdata m_tuser             m_tuser: status
//
// Alloc reads the area table memory once, and once more per exhausted area skipped.
// Add and undefined ops go through the S_SIMPLE state only.
// Exclude reads every stored area and writes back each one that is kept.
// Synchronous active-low reset clears control only; no clearing pass on the memory.
// A result waits in the output register; the final cycle of the next request
// holds while that register is still full.
module page_frame_region_allocator #(
    parameter int MAX_REGIONS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*pfra_pkg::ADDR_BITS-1:0]  s_tdata,  // region_address, region_length
    input  logic [2:0]                        s_tuser,  // op[1:0], usable
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfra_pkg::ADDR_BITS-1:0]    m_tdata,  // frame_address
    output logic [2:0]                        m_tuser   // status
);

    localparam int AB    = pfra_pkg::ADDR_BITS;
    localparam int PS    = pfra_pkg::PAGE_SHIFT;
    localparam int FB    = pfra_pkg::FRAME_BITS;
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    pfra_pkg::state_t  state_reg, state_next;
    pfra_pkg::op_t     op_reg;
    logic [AB-1:0]     addr_reg, len_reg;
    logic              usable_reg;
    logic [AB:0]       bend_reg;

    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  curn_reg, curn_next;
    logic              mid_reg, mid_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [AB-1:0]        m_frame_reg, m_frame_next;
    pfra_pkg::status_t    m_status_reg, m_status_next;

    pfra_pkg::area_t   mem [MAX_REGIONS];
    pfra_pkg::area_t   rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    pfra_pkg::area_t   wr_data;

    logic              accept;
    logic              out_free;
    logic [CNT_W-1:0]  cur_inc;

    logic [FB-1:0]     lo;
    logic [FB:0]       bend_frame;
    logic [FB+1:0]     hi;
    logic [FB:0]       add_first, add_last, frame_limit;
    logic              add_small;
    logic [FB-1:0]     add_count;

    logic [FB+1:0]     ex_s, ex_e, ex_lo;
    logic [FB:0]       ex_end;
    logic              ex_head, ex_drop, ex_tail, ex_mid;
    pfra_pkg::area_t   ex_area;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cur_inc  = cur_reg + CNT_W'(1);

    assign s_tready = (state_reg == pfra_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_frame_reg;
    assign m_tuser  = m_status_reg;

    // Page arithmetic on the held request
    assign lo          = addr_reg[AB-1:PS];
    assign bend_frame  = bend_reg[AB:PS];
    assign hi          = {1'b0, bend_frame} + (FB+2)'(|bend_reg[PS-1:0]);
    assign frame_limit = {1'b1, {FB{1'b0}}};
    assign add_first   = {1'b0, lo} + (FB+1)'(|addr_reg[PS-1:0]);
    assign add_last    = (bend_frame > frame_limit) ? frame_limit : bend_frame;
    assign add_small   = (len_reg <= AB'(pfra_pkg::PAGE_BYTES));
    assign add_count   = FB'(add_last - add_first);

    // Exclude trim on the entry just read
    assign ex_end  = {1'b0, rd_data_reg.start_frame} + {1'b0, rd_data_reg.frame_count};
    assign ex_s    = {2'b00, rd_data_reg.start_frame};
    assign ex_e    = {1'b0, ex_end};
    assign ex_lo   = {2'b00, lo};
    assign ex_head = (ex_lo <= ex_s) && (hi > ex_s);
    assign ex_drop = ex_head && (hi >= ex_e);
    assign ex_tail = !ex_head && (ex_lo < ex_e) && (hi >= ex_e);
    assign ex_mid  = !ex_head && !ex_tail &&
                     (((ex_lo > ex_s) && (ex_lo < ex_e)) || ((hi > ex_s) && (hi < ex_e)));

    always_comb begin
        ex_area = rd_data_reg;
        if (ex_head) begin
            ex_area.start_frame = FB'(hi);
            ex_area.frame_count = FB'(ex_e - hi);
            ex_area.next_free   = FB'(hi);
            ex_area.free_left   = FB'(ex_e - hi);
        end else if (ex_tail) begin
            ex_area.frame_count = FB'(ex_lo - ex_s);
            ex_area.next_free   = rd_data_reg.start_frame;
            ex_area.free_left   = FB'(ex_lo - ex_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfra_pkg::S_IDLE;
            total_reg    <= '0;
            cur_reg      <= '0;
            r_reg        <= '0;
            w_reg        <= '0;
            curn_reg     <= '0;
            mid_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            cur_reg      <= cur_next;
            r_reg        <= r_next;
            w_reg        <= w_next;
            curn_reg     <= curn_next;
            mid_reg      <= mid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= pfra_pkg::op_t'(s_tuser[1:0]);
            usable_reg <= s_tuser[2];
            addr_reg   <= s_tdata[AB-1:0];
            len_reg    <= s_tdata[2*AB-1:AB];
            bend_reg   <= {1'b0, s_tdata[AB-1:0]} + {1'b0, s_tdata[2*AB-1:AB]};
        end
        m_frame_reg  <= m_frame_next;
        m_status_reg <= m_status_next;
    end

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        cur_next      = cur_reg;
        r_next        = r_reg;
        w_next        = w_reg;
        curn_next     = curn_reg;
        mid_next      = mid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_frame_next  = m_frame_reg;
        m_status_next = m_status_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = w_reg[IDX_W-1:0];
        wr_data       = ex_area;

        case (state_reg)
            pfra_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    case (pfra_pkg::op_t'(s_tuser[1:0]))
                        pfra_pkg::OP_EXCLUDE: begin
                            r_next     = '0;
                            w_next     = '0;
                            curn_next  = '0;
                            mid_next   = 1'b0;
                            state_next = pfra_pkg::S_EX_RD;
                        end
                        pfra_pkg::OP_ALLOC: begin
                            rd_en      = 1'b1;
                            state_next = pfra_pkg::S_AL_CHK;
                        end
                        default: begin
                            state_next = pfra_pkg::S_SIMPLE;
                        end
                    endcase
                end
            end

            pfra_pkg::S_SIMPLE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_frame_next  = '0;
                    state_next    = pfra_pkg::S_IDLE;
                    if (op_reg != pfra_pkg::OP_ADD) begin
                        m_status_next = pfra_pkg::ST_IGNORED;
                    end else if (!usable_reg || add_small || (add_first >= add_last)) begin
                        m_status_next = pfra_pkg::ST_IGNORED;
                    end else if (total_reg >= CNT_W'(MAX_REGIONS)) begin
                        m_status_next = pfra_pkg::ST_FULL;
                    end else begin
                        m_status_next = pfra_pkg::ST_OK;
                        wr_en         = 1'b1;
                        wr_addr       = total_reg[IDX_W-1:0];
                        wr_data       = '{start_frame: add_first[FB-1:0],
                                          frame_count: add_count,
                                          next_free:   add_first[FB-1:0],
                                          free_left:   add_count};
                        total_next    = total_reg + CNT_W'(1);
                    end
                end
            end

            pfra_pkg::S_EX_RD: begin
                if (r_reg == total_reg) begin
                    state_next = pfra_pkg::S_EX_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = r_reg[IDX_W-1:0];
                    state_next = pfra_pkg::S_EX_MOD;
                end
            end

            pfra_pkg::S_EX_MOD: begin
                // compact kept entries down to the write index
                if (!ex_drop) begin
                    wr_en  = 1'b1;
                    w_next = w_reg + CNT_W'(1);
                    if (r_reg < cur_reg) begin
                        curn_next = curn_reg + CNT_W'(1);
                    end
                end
                if (ex_mid) begin
                    mid_next = 1'b1;
                end
                r_next     = r_reg + CNT_W'(1);
                state_next = pfra_pkg::S_EX_RD;
            end

            pfra_pkg::S_EX_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_frame_next  = '0;
                    m_status_next = mid_reg ? pfra_pkg::ST_MIDDLE : pfra_pkg::ST_OK;
                    total_next    = w_reg;
                    cur_next      = curn_reg;
                    state_next    = pfra_pkg::S_IDLE;
                end
            end

            pfra_pkg::S_AL_CHK: begin
                if (cur_reg >= total_reg) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_frame_next  = '0;
                        m_status_next = pfra_pkg::ST_OOM;
                        state_next    = pfra_pkg::S_IDLE;
                    end
                end else if (rd_data_reg.free_left == '0) begin
                    // skip an exhausted area
                    cur_next = cur_inc;
                    rd_en    = 1'b1;
                    rd_addr  = cur_inc[IDX_W-1:0];
                end else if (out_free) begin
                    wr_en             = 1'b1;
                    wr_addr           = cur_reg[IDX_W-1:0];
                    wr_data           = rd_data_reg;
                    wr_data.next_free = rd_data_reg.next_free + FB'(1);
                    wr_data.free_left = rd_data_reg.free_left - FB'(1);
                    if (rd_data_reg.free_left == FB'(1)) begin
                        cur_next = cur_inc;
                    end
                    m_tvalid_next = 1'b1;
                    m_frame_next  = AB'({rd_data_reg.next_free, {PS{1'b0}}});
                    m_status_next = pfra_pkg::ST_OK;
                    state_next    = pfra_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pfra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ design/pfra_checker.sv @@
`include "page_frame_region_allocator_macros.svh"

module pfra_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pfra_pkg::ADDR_BITS-1:0] m_tdata,
    input logic [2:0]                     m_tuser
);

    `PFRA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `PFRA_ASSERT_IMP(a_status_range, m_tvalid, m_tuser <= 3'(pfra_pkg::ST_FULL), "status code out of range")
    `PFRA_ASSERT_IMP(a_frame_zero, m_tvalid && (m_tuser != 3'(pfra_pkg::ST_OK)), m_tdata == '0, "frame given with a failing status")
    `PFRA_ASSERT_IMP(a_frame_align, m_tvalid, m_tdata[pfra_pkg::PAGE_SHIFT-1:0] == '0, "frame not page aligned")
    `PFRA_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready stayed high after a request")

endmodule

bind page_frame_region_allocator pfra_checker u_pfra_checker (.*);

@@ tb/page_frame_region_allocator_tb.sv @@
module page_frame_region_allocator_tb;

    localparam int AREA_SLOTS     = 16;
    localparam int RANDOM_ITEMS   = 1580;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 3 + 2 * AREA_SLOTS + 8;
    localparam int AB             = pfra_pkg::ADDR_BITS;
    localparam int FRAME_BITS     = pfra_pkg::FRAME_BITS;
    localparam int PAGE_SHIFT     = pfra_pkg::PAGE_SHIFT;
    localparam int PAGE_BYTES     = pfra_pkg::PAGE_BYTES;
    localparam logic [63:0] FRAME_CAP = 64'd1 << FRAME_BITS;

    typedef logic [63:0] wide_t;

    typedef struct {
        logic [AB-1:0]     frame;
        pfra_pkg::status_t status;
    } reply_t;

    typedef struct {
        pfra_pkg::op_t     op;
        logic [AB-1:0]     addr;
        logic [AB-1:0]     len;
        logic              usable;
        bit                typed;
        logic [AB-1:0]     frame;
        pfra_pkg::status_t status;
    } script_row_t;

    typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_CARVE} mix_t;

    logic            aclk;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [2*AB-1:0] s_tdata  = '0;  // region_address, region_length
    logic [2:0]      s_tuser  = '0;  // op[1:0], usable
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [AB-1:0]   m_tdata;        // frame_address
    logic [2:0]      m_tuser;        // status

    wide_t area_first [AREA_SLOTS];
    wide_t area_len   [AREA_SLOTS];
    wide_t area_next  [AREA_SLOTS];
    wide_t area_left  [AREA_SLOTS];
    int    area_count  = 0;
    int    area_cursor = 0;

    reply_t      replies_due[$];
    script_row_t script[$];
    int          errors       = 0;
    int          sent         = 0;
    int          checked      = 0;
    int          stall_cycles = 0;
    int          status_tally[8];
    bit          no_gaps      = 1'b0;

    page_frame_region_allocator #(
        .MAX_REGIONS(AREA_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void remove_area(int idx);
        for (int i = idx; i + 1 < area_count; i++) begin
            area_first[i] = area_first[i+1];
            area_len[i]   = area_len[i+1];
            area_next[i]  = area_next[i+1];
            area_left[i]  = area_left[i+1];
        end
        area_len[area_count-1] = '0;
        area_count--;
        if (idx < area_cursor) begin
            area_cursor--;
        end
    endfunction

    function automatic pfra_pkg::status_t add_area(wide_t addr, wide_t len, logic usable);
        wide_t first;
        wide_t last;
        if (!usable || len <= wide_t'(PAGE_BYTES)) begin
            return pfra_pkg::ST_IGNORED;
        end
        first = addr >> PAGE_SHIFT;
        if (addr[PAGE_SHIFT-1:0] != '0) begin
            first++;
        end
        last = (addr + len) >> PAGE_SHIFT;
        if (last > FRAME_CAP) begin
            last = FRAME_CAP;
        end
        if (first >= last) begin
            return pfra_pkg::ST_IGNORED;
        end
        if (area_count >= AREA_SLOTS) begin
            return pfra_pkg::ST_FULL;
        end
        area_first[area_count] = first;
        area_len[area_count]   = last - first;
        area_next[area_count]  = first;
        area_left[area_count]  = last - first;
        area_count++;
        return pfra_pkg::ST_OK;
    endfunction

    function automatic pfra_pkg::status_t exclude_area(wide_t addr, wide_t len);
        wide_t             stop;
        wide_t             lo;
        wide_t             hi;
        wide_t             s;
        wide_t             e;
        pfra_pkg::status_t st;
        int                i;
        stop = addr + len;
        lo   = addr >> PAGE_SHIFT;
        hi   = stop >> PAGE_SHIFT;
        if (stop[PAGE_SHIFT-1:0] != '0) begin
            hi++;
        end
        st = pfra_pkg::ST_OK;
        i  = 0;
        while (i < area_count) begin
            s = area_first[i];
            e = s + area_len[i];
            if (lo <= s && hi > s) begin
                if (hi >= e) begin
                    remove_area(i);
                    continue;
                end
                area_first[i] = hi;
                area_len[i]   = e - hi;
                area_next[i]  = hi;
                area_left[i]  = e - hi;
            end else if (lo < e && hi >= e) begin
                area_len[i]  = lo - s;
                area_next[i] = s;
                area_left[i] = lo - s;
            end else if ((lo > s && lo < e) || (hi > s && hi < e)) begin
                st = pfra_pkg::ST_MIDDLE;
            end
            i++;
        end
        return st;
    endfunction

    function automatic pfra_pkg::status_t grant_frame(output logic [AB-1:0] frame);
        wide_t f;
        wide_t byte_addr;
        frame = '0;
        while (area_cursor < area_count && area_left[area_cursor] == '0) begin
            area_cursor++;
        end
        if (area_cursor >= area_count) begin
            return pfra_pkg::ST_OOM;
        end
        f = area_next[area_cursor];
        area_next[area_cursor] = f + 64'd1;
        area_left[area_cursor]--;
        if (area_left[area_cursor] == '0) begin
            area_cursor++;
        end
        byte_addr = f << PAGE_SHIFT;
        frame = byte_addr[AB-1:0];
        return pfra_pkg::ST_OK;
    endfunction

    function automatic reply_t allocator_reply(pfra_pkg::op_t op, logic [AB-1:0] addr,
                                               logic [AB-1:0] len, logic usable);
        reply_t        r;
        logic [AB-1:0] f;
        r.frame = '0;
        case (op)
            pfra_pkg::OP_ADD: begin
                r.status = add_area(wide_t'(addr), wide_t'(len), usable);
            end
            pfra_pkg::OP_EXCLUDE: begin
                r.status = exclude_area(wide_t'(addr), wide_t'(len));
            end
            pfra_pkg::OP_ALLOC: begin
                r.status = grant_frame(f);
                r.frame  = f;
            end
            default: begin
                r.status = pfra_pkg::ST_IGNORED;
            end
        endcase
        return r;
    endfunction

    function automatic logic [AB-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[AB-1:0];
    endfunction

    function automatic void pick_region(input logic [FRAME_BITS-1:0] base, input bit wide,
                                        output logic [AB-1:0] addr,
                                        output logic [AB-1:0] len);
        wide_t a;
        wide_t l;
        if ($urandom_range(0, 15) == 0) begin
            addr = rand48();
            len  = rand48();
            return;
        end
        a = (wide_t'(base) + wide_t'($urandom_range(0, 47))) << PAGE_SHIFT;
        if ($urandom_range(0, 1) != 0) begin
            a += wide_t'($urandom_range(0, PAGE_BYTES - 1));
        end
        if (wide) begin
            l = wide_t'($urandom_range(8, 64)) << PAGE_SHIFT;
        end else begin
            l = wide_t'($urandom_range(0, 10)) << PAGE_SHIFT;
            if ($urandom_range(0, 1) != 0) begin
                l += wide_t'($urandom_range(0, PAGE_BYTES - 1));
            end
        end
        addr = a[AB-1:0];
        len  = l[AB-1:0];
    endfunction

    function automatic void put(pfra_pkg::op_t op, logic [AB-1:0] addr,
                                logic [AB-1:0] len, logic usable, bit typed,
                                logic [AB-1:0] frame, pfra_pkg::status_t status);
        script.push_back('{op, addr, len, usable, typed, frame, status});
    endfunction

    task automatic send_request(pfra_pkg::op_t op, logic [AB-1:0] addr,
                                logic [AB-1:0] len, logic usable, bit typed,
                                logic [AB-1:0] t_frame, pfra_pkg::status_t t_status);
        reply_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, addr};
        s_tuser  <= {usable, op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = allocator_reply(op, addr, len, usable);
        if (typed) begin
            predicted.frame  = t_frame;
            predicted.status = t_status;
        end
        replies_due.push_back(predicted);
        sent++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result: frame %h status %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = replies_due.pop_front();
                checked++;
                status_tally[m_tuser]++;
                if (m_tdata !== want.frame) begin
                    $display("%0t: frame_address mismatch: expected %h, got %h",
                             $time, want.frame, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mix_t                  mix;
        int                    seg_left;
        int                    w_add;
        int                    w_ex;
        int                    roll;
        int                    directed;
        logic [63:0]           r64;
        logic [FRAME_BITS-1:0] base;
        pfra_pkg::op_t         op;
        logic [AB-1:0]         addr;
        logic [AB-1:0]         len;
        logic                  usable;

        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b1, '0, pfra_pkg::ST_OOM);
        put(pfra_pkg::OP_EXCLUDE, '0, '0, 1'b0, 1'b1, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_NONE,    '1, '1, 1'b1, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, 48'h1000, 48'h10000, 1'b0, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, 48'h1000, 48'h1000,  1'b1, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, '0,       '0,        1'b1, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, 48'h1001, 48'h1001,  1'b1, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, '1,       '1,        1'b1, 1'b1, '0, pfra_pkg::ST_IGNORED);
        put(pfra_pkg::OP_ADD, 48'h1800, 48'h5000,  1'b1, 1'b1, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ADD, 48'hFFFF_FFFF_C000, 48'h10000, 1'b1, 1'b1, '0,
            pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b1, 48'h2000, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_EXCLUDE, 48'h3000, 48'h1000, 1'b0, 1'b1, '0, pfra_pkg::ST_MIDDLE);
        put(pfra_pkg::OP_EXCLUDE, 48'h1000, 48'h2800, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_EXCLUDE, 48'hFFFF_FFFF_E000, '1, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b1, '0, pfra_pkg::ST_OOM);
        put(pfra_pkg::OP_EXCLUDE, '0, '1, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ADD,     '0, '1, 1'b1, 1'b0, '0, pfra_pkg::ST_OK);
        put(pfra_pkg::OP_ALLOC,   '0, '0, 1'b0, 1'b0, '0, pfra_pkg::ST_OK);
        directed = script.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_request(script[i].op, script[i].addr, script[i].len, script[i].usable,
                         script[i].typed, script[i].frame, script[i].status);
        end

        seg_left = 0;
        mix      = MIX_FILL;
        base     = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                if (n != 0) begin
                    mix = mix_t'($urandom_range(0, 3));
                end
                r64  = {$urandom, $urandom};
                base = r64[FRAME_BITS-1:0];
                case ($urandom_range(0, 3))
                    0: base = FRAME_BITS'($urandom_range(0, 200));
                    1: base = FRAME_BITS'(FRAME_CAP - 40);
                    default: begin
                        if (wide_t'(base) > FRAME_CAP - 120) begin
                            base = FRAME_BITS'(FRAME_CAP - 120);
                        end
                    end
                endcase
            end
            seg_left--;
            no_gaps = (n >= 700 && n < 1000);

            case (mix)
                MIX_FILL:     begin w_add = 70; w_ex = 5;  end
                MIX_BALANCED: begin w_add = 25; w_ex = 20; end
                MIX_DRAIN:    begin w_add = 8;  w_ex = 7;  end
                default:      begin w_add = 15; w_ex = 45; end
            endcase

            usable = 1'b0;
            roll   = $urandom_range(0, 99);
            if (roll < 2) begin
                // wipe the whole table, or a random span from address zero
                op   = pfra_pkg::OP_EXCLUDE;
                addr = '0;
                len  = ($urandom_range(0, 1) != 0) ? '1 : rand48();
            end else if (roll < 6) begin
                op     = pfra_pkg::op_t'($urandom_range(0, 3));
                addr   = rand48();
                len    = rand48();
                usable = 1'($urandom_range(0, 1));
            end else if (roll < 9) begin
                op     = pfra_pkg::OP_NONE;
                addr   = rand48();
                len    = rand48();
                usable = 1'($urandom_range(0, 1));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < w_add) begin
                    op     = pfra_pkg::OP_ADD;
                    usable = ($urandom_range(0, 9) != 0);
                    pick_region(base, $urandom_range(0, 4) == 0, addr, len);
                end else if (roll < w_add + w_ex) begin
                    op = pfra_pkg::OP_EXCLUDE;
                    pick_region(base, $urandom_range(0, 9) < 3, addr, len);
                end else begin
                    op   = pfra_pkg::OP_ALLOC;
                    addr = '0;
                    len  = '0;
                end
            end
            send_request(op, addr, len, usable, 1'b0, '0, pfra_pkg::ST_OK);
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (replies_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d directed, %0d random), checked %0d results.",
                 sent, directed, sent - directed, checked);
        $display("Statuses: ok %0d, ignored %0d, middle %0d, out of memory %0d, full %0d.",
                 status_tally[pfra_pkg::ST_OK], status_tally[pfra_pkg::ST_IGNORED],
                 status_tally[pfra_pkg::ST_MIDDLE], status_tally[pfra_pkg::ST_OOM],
                 status_tally[pfra_pkg::ST_FULL]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
